// ===== rtl/core/tmwc_pkg.sv =====
// Package with shared constants and types for the trimmed mean window classifier.
`default_nettype none
package tmwc_pkg;

  localparam int unsigned SampleW      = 12;
  localparam int unsigned StateW       = 2;
  localparam int unsigned TrimShiftDef = 3;
  localparam int unsigned ApbAddrW     = 5;
  localparam int unsigned ApbDataW     = 32;
  localparam int unsigned InTdataW     = 16;
  localparam int unsigned OutTdataW    = 16;
  localparam int unsigned RegIdxW      = 3;

  localparam logic [SampleW-1:0] SampleMax = {SampleW{1'b1}};

  localparam logic [SampleW-1:0] StandbyLowRst  = 12'd459;
  localparam logic [SampleW-1:0] StandbyHighRst = 12'd657;
  localparam logic [SampleW-1:0] DetectedLowRst  = 12'd831;
  localparam logic [SampleW-1:0] DetectedHighRst = 12'd1029;
  localparam logic [SampleW-1:0] ReadyLowRst  = 12'd1203;
  localparam logic [SampleW-1:0] ReadyHighRst = 12'd1402;

  localparam logic [RegIdxW-1:0] RegStandbyLow   = 3'd0;
  localparam logic [RegIdxW-1:0] RegStandbyHigh  = 3'd1;
  localparam logic [RegIdxW-1:0] RegDetectedLow  = 3'd2;
  localparam logic [RegIdxW-1:0] RegDetectedHigh = 3'd3;
  localparam logic [RegIdxW-1:0] RegReadyLow     = 3'd4;
  localparam logic [RegIdxW-1:0] RegReadyHigh    = 3'd5;

  localparam logic [StateW-1:0] CodeStandby  = 2'd0;
  localparam logic [StateW-1:0] CodeDetected = 2'd1;
  localparam logic [StateW-1:0] CodeReady    = 2'd2;
  localparam logic [StateW-1:0] CodeNone     = 2'd3;

  typedef struct packed {
    logic [SampleW-1:0] standby_low;
    logic [SampleW-1:0] standby_high;
    logic [SampleW-1:0] detected_low;
    logic [SampleW-1:0] detected_high;
    logic [SampleW-1:0] ready_low;
    logic [SampleW-1:0] ready_high;
  } bounds_t;

  typedef struct packed {
    logic               valid;
    logic [SampleW-1:0] mean;
  } mean_req_t;

endpackage
`default_nettype wire

// ===== rtl/core/tmwc_regs.sv =====
// APB register file holding the six window bounds.
`default_nettype none
module tmwc_regs
  import tmwc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ApbAddrW-1:0] paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output logic      [ApbDataW-1:0] prdata,
  output logic                     pready,
  output bounds_t                  bounds_o
);

  bounds_t            bounds_q;
  logic [RegIdxW-1:0] idx;
  logic               wr_en;
  logic [SampleW-1:0] wval;
  logic [SampleW-1:0] rval;

  assign idx    = paddr[ApbAddrW-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign wval   = pwdata[SampleW-1:0];
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bounds_q.standby_low   <= StandbyLowRst;
      bounds_q.standby_high  <= StandbyHighRst;
      bounds_q.detected_low  <= DetectedLowRst;
      bounds_q.detected_high <= DetectedHighRst;
      bounds_q.ready_low     <= ReadyLowRst;
      bounds_q.ready_high    <= ReadyHighRst;
    end else if (wr_en) begin
      case (idx)
        RegStandbyLow:   bounds_q.standby_low   <= wval;
        RegStandbyHigh:  bounds_q.standby_high  <= wval;
        RegDetectedLow:  bounds_q.detected_low  <= wval;
        RegDetectedHigh: bounds_q.detected_high <= wval;
        RegReadyLow:     bounds_q.ready_low     <= wval;
        RegReadyHigh:    bounds_q.ready_high    <= wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegStandbyLow:   rval = bounds_q.standby_low;
      RegStandbyHigh:  rval = bounds_q.standby_high;
      RegDetectedLow:  rval = bounds_q.detected_low;
      RegDetectedHigh: rval = bounds_q.detected_high;
      RegReadyLow:     rval = bounds_q.ready_low;
      RegReadyHigh:    rval = bounds_q.ready_high;
      default:         rval = '0;
    endcase
  end

  assign prdata   = {{(ApbDataW-SampleW){1'b0}}, rval};
  assign bounds_o = bounds_q;

endmodule
`default_nettype wire

// ===== rtl/core/tmwc_accum.sv =====
// Input register and running sum, minimum and maximum over one frame.
`default_nettype none
module tmwc_accum
  import tmwc_pkg::*;
#(
  parameter int unsigned TRIM_SHIFT = TrimShiftDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [SampleW-1:0] sample_i,
  input  wire logic               mean_ready_i,
  output mean_req_t               mean_o
);

  localparam int unsigned FrameLen = (1 << TRIM_SHIFT) + 2;
  localparam int unsigned CountW   = $clog2(FrameLen);
  localparam int unsigned SumW     = SampleW + $clog2(FrameLen);
  localparam logic [CountW-1:0] LastCount = CountW'(FrameLen - 1);

  logic               iv_q, iv_d;
  logic [SampleW-1:0] sample_q;
  logic [CountW-1:0]  count_q, count_d;
  logic [SumW-1:0]    sum_q, sum_d;
  logic [SampleW-1:0] min_q, min_d;
  logic [SampleW-1:0] max_q, max_d;
  logic               mv_q, mv_d;
  logic [SampleW-1:0] mean_q, mean_d;

  logic               frame_end;
  logic               consume;
  logic               accept;
  logic [SumW-1:0]    new_sum;
  logic [SampleW-1:0] new_min;
  logic [SampleW-1:0] new_max;
  logic [SumW-1:0]    trimmed;

  assign frame_end  = (count_q == LastCount);
  assign consume    = iv_q && (!frame_end || !mv_q || mean_ready_i);
  assign in_ready_o = !iv_q || consume;
  assign accept     = in_valid_i && in_ready_o;

  assign new_sum = sum_q + SumW'(sample_q);
  assign new_min = (sample_q < min_q) ? sample_q : min_q;
  assign new_max = (sample_q > max_q) ? sample_q : max_q;
  assign trimmed = new_sum - SumW'(new_min) - SumW'(new_max);

  always_comb begin
    iv_d    = iv_q;
    count_d = count_q;
    sum_d   = sum_q;
    min_d   = min_q;
    max_d   = max_q;
    mv_d    = mv_q && !mean_ready_i;
    mean_d  = mean_q;
    if (consume) begin
      iv_d = 1'b0;
      if (frame_end) begin
        count_d = '0;
        sum_d   = '0;
        min_d   = SampleMax;
        max_d   = '0;
        mv_d    = 1'b1;
        mean_d  = trimmed[TRIM_SHIFT +: SampleW];
      end else begin
        count_d = count_q + 1'b1;
        sum_d   = new_sum;
        min_d   = new_min;
        max_d   = new_max;
      end
    end
    if (accept) begin
      iv_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q    <= 1'b0;
      count_q <= '0;
      sum_q   <= '0;
      min_q   <= SampleMax;
      max_q   <= '0;
      mv_q    <= 1'b0;
    end else begin
      iv_q    <= iv_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      min_q   <= min_d;
      max_q   <= max_d;
      mv_q    <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= sample_i;
    end
    mean_q <= mean_d;
  end

  assign mean_o.valid = mv_q;
  assign mean_o.mean  = mean_q;

endmodule
`default_nettype wire

// ===== rtl/core/tmwc_classify.sv =====
// Window comparison, change detection and the result register.
`default_nettype none
module tmwc_classify
  import tmwc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  mean_req_t              mean_i,
  output logic                   mean_ready_o,
  input  bounds_t                bounds_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [StateW-1:0]      pilot_state_o,
  output logic [SampleW-1:0]     mean_value_o
);

  logic               ov_q, ov_d;
  logic [StateW-1:0]  last_q, last_d;
  logic [StateW-1:0]  state_q, state_d;
  logic [SampleW-1:0] value_q, value_d;
  logic               take;
  logic               hit;
  logic [StateW-1:0]  code;
  logic               in_sb, in_det, in_rdy;

  assign mean_ready_o = !ov_q || out_ready_i;
  assign take         = mean_i.valid && mean_ready_o;

  assign in_sb  = (mean_i.mean > bounds_i.standby_low) &&
                  (mean_i.mean < bounds_i.standby_high);
  assign in_det = (mean_i.mean > bounds_i.detected_low) &&
                  (mean_i.mean < bounds_i.detected_high);
  assign in_rdy = (mean_i.mean > bounds_i.ready_low) &&
                  (mean_i.mean < bounds_i.ready_high);

  always_comb begin
    hit  = 1'b1;
    code = CodeNone;
    if (in_sb) begin
      code = CodeStandby;
    end else if (in_det) begin
      code = CodeDetected;
    end else if (in_rdy) begin
      code = CodeReady;
    end else begin
      hit = 1'b0;
    end
  end

  always_comb begin
    ov_d    = ov_q && !out_ready_i;
    last_d  = last_q;
    state_d = state_q;
    value_d = value_q;
    if (take && hit && (code != last_q)) begin
      ov_d    = 1'b1;
      last_d  = code;
      state_d = code;
      value_d = mean_i.mean;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q   <= 1'b0;
      last_q <= CodeNone;
    end else begin
      ov_q   <= ov_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    state_q <= state_d;
    value_q <= value_d;
  end

  assign out_valid_o   = ov_q;
  assign pilot_state_o = state_q;
  assign mean_value_o  = value_q;

endmodule
`default_nettype wire

// ===== rtl/core/trimmed_mean_window_classifier.sv =====
// Top level of the trimmed mean window classifier.
//
//   Channel  Direction  Contents
//   s_axis   in         one 12-bit sample per request
//   m_axis   out        state code and trimmed mean, at most one per frame
//   apb      in/out     six 12-bit window bounds
//
// One sample is taken per cycle while the input does not stall. A frame
// of 2^TRIM_SHIFT+2 samples yields its mean in the mean register once its
// last sample leaves the input register, then any report in the output
// register, which lets samples keep flowing while a report waits; input
// stalls only when a report waits, a further mean waits behind it and the
// last sample of another frame has arrived. Reset clears the frame
// statistics and the last reported code and restores the default bounds.
`default_nettype none
module trimmed_mean_window_classifier
  import tmwc_pkg::*;
#(
  parameter int unsigned TRIM_SHIFT = TrimShiftDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // [11:0] sample
  input  wire logic [InTdataW-1:0]  s_axis_tdata_i,
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // [1:0] pilot_state, [13:2] mean_value
  output logic      [OutTdataW-1:0] m_axis_tdata_o,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ApbAddrW-1:0]  paddr,
  input  wire logic [ApbDataW-1:0]  pwdata,
  output logic      [ApbDataW-1:0]  prdata,
  output logic                      pready
);

  bounds_t            bounds;
  mean_req_t          mean_req;
  logic               mean_ready;
  logic [StateW-1:0]  pilot_state;
  logic [SampleW-1:0] mean_value;

  tmwc_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .bounds_o (bounds)
  );

  tmwc_accum #(
    .TRIM_SHIFT (TRIM_SHIFT)
  ) u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .sample_i     (s_axis_tdata_i[SampleW-1:0]),
    .mean_ready_i (mean_ready),
    .mean_o       (mean_req)
  );

  tmwc_classify u_classify (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mean_i        (mean_req),
    .mean_ready_o  (mean_ready),
    .bounds_i      (bounds),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .pilot_state_o (pilot_state),
    .mean_value_o  (mean_value)
  );

  assign m_axis_tdata_o = {{(OutTdataW-StateW-SampleW){1'b0}}, mean_value, pilot_state};

endmodule
`default_nettype wire

// ===== tb/sv/tb_trimmed_mean_window_classifier.sv =====
// Self-checking testbench for the trimmed mean window classifier: sample streams against a predictor.
`timescale 1ns / 100ps
module tb_trimmed_mean_window_classifier;
  import tmwc_pkg::*;

  localparam int          SampleTop   = int'(SampleMax);
  localparam int          FrameLen    = (1 << TrimShiftDef) + 2;
  localparam int          SumW        = SampleW + TrimShiftDef + 1;
  localparam int          SettleCycles = 8;
  localparam int          QuietLimit  = 2000;
  localparam int          DirectedLen = 25;
  localparam logic [RegIdxW-1:0] RegSpareLow  = 3'd6;
  localparam logic [RegIdxW-1:0] RegSpareHigh = 3'd7;

  typedef struct packed {
    logic [StateW-1:0]  code;
    logic [SampleW-1:0] mean;
  } report_t;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               typed;
    report_t            want;
  } stim_row_t;

  typedef enum int {
    PhaseDefault, PhaseOverlap, PhaseRandomA, PhaseEmpty, PhaseRandomB, PhaseRestore, PhaseCount
  } phase_e;

  // Two frames with reports that follow directly from the reset bounds, then a partial frame.
  localparam stim_row_t [0:DirectedLen-1] DirectedRows = {
    {12'd0,    1'b0, CodeNone,     12'd0},
    {12'd500,  1'b0, CodeNone,     12'd0},
    {12'd500,  1'b0, CodeNone,     12'd0},
    {12'd500,  1'b0, CodeNone,     12'd0},
    {12'd4095, 1'b0, CodeNone,     12'd0},
    {12'd500,  1'b0, CodeNone,     12'd0},
    {12'd500,  1'b0, CodeNone,     12'd0},
    {12'd500,  1'b0, CodeNone,     12'd0},
    {12'd500,  1'b0, CodeNone,     12'd0},
    {12'd500,  1'b1, CodeStandby,  12'd500},
    {12'd4094, 1'b0, CodeNone,     12'd0},
    {12'd1000, 1'b0, CodeNone,     12'd0},
    {12'd1001, 1'b0, CodeNone,     12'd0},
    {12'd1002, 1'b0, CodeNone,     12'd0},
    {12'd1,    1'b0, CodeNone,     12'd0},
    {12'd1003, 1'b0, CodeNone,     12'd0},
    {12'd1004, 1'b0, CodeNone,     12'd0},
    {12'd1005, 1'b0, CodeNone,     12'd0},
    {12'd1006, 1'b0, CodeNone,     12'd0},
    {12'd1007, 1'b1, CodeDetected, 12'd1003},
    {12'hAAA,  1'b0, CodeNone,     12'd0},
    {12'h555,  1'b0, CodeNone,     12'd0},
    {12'hFFF,  1'b0, CodeNone,     12'd0},
    {12'h000,  1'b0, CodeNone,     12'd0},
    {12'h800,  1'b0, CodeNone,     12'd0}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [InTdataW-1:0]  s_axis_tdata_i = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata_o;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ApbAddrW-1:0]  paddr = '0;
  logic [ApbDataW-1:0]  pwdata = '0;
  logic [ApbDataW-1:0]  prdata;
  logic                 pready;

  logic [SampleW-1:0]   bound_q [6];
  logic [3:0]           frame_cnt = '0;
  logic [SumW-1:0]      frame_sum = '0;
  logic [SampleW-1:0]   frame_min = SampleMax;
  logic [SampleW-1:0]   frame_max = '0;
  logic [StateW-1:0]    last_code = CodeNone;
  report_t              report_q [$];

  int send_idle_pct = 13;
  int recv_idle_pct = 59;
  int mismatches = 0;
  int quiet_cycles = 0;
  int aim = 0;
  int spread = 0;
  bit wild = 1'b0;

  trimmed_mean_window_classifier #(
    .TRIM_SHIFT(TrimShiftDef)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic logic in_window(input logic [SampleW-1:0] v, input logic [SampleW-1:0] lo,
                                     input logic [SampleW-1:0] hi);
    return (v > lo) && (v < hi);
  endfunction

  function automatic void take_sample(input logic [SampleW-1:0] s, output logic made,
                                      output report_t rep);
    logic [SumW-1:0] trimmed;
    made = 1'b0;
    rep = '0;
    frame_sum += SumW'(s);
    if (s < frame_min) frame_min = s;
    if (s > frame_max) frame_max = s;
    frame_cnt++;
    if (frame_cnt == FrameLen) begin
      trimmed = frame_sum - SumW'(frame_min) - SumW'(frame_max);
      rep.mean = trimmed[TrimShiftDef +: SampleW];
      frame_cnt = '0;
      frame_sum = '0;
      frame_min = SampleMax;
      frame_max = '0;
      made = 1'b1;
      if (in_window(rep.mean, bound_q[RegStandbyLow], bound_q[RegStandbyHigh])) begin
        rep.code = CodeStandby;
      end else if (in_window(rep.mean, bound_q[RegDetectedLow], bound_q[RegDetectedHigh])) begin
        rep.code = CodeDetected;
      end else if (in_window(rep.mean, bound_q[RegReadyLow], bound_q[RegReadyHigh])) begin
        rep.code = CodeReady;
      end else begin
        made = 1'b0;
      end
      if (made && rep.code == last_code) made = 1'b0;
      if (made) last_code = rep.code;
    end
  endfunction

  function automatic void pick_aim();
    int w;
    int lo;
    int hi;
    wild = ($urandom_range(9) == 0);
    spread = $urandom_range(6);
    w = $urandom_range(2);
    lo = bound_q[2 * w];
    hi = bound_q[2 * w + 1];
    if ($urandom_range(4) == 0) begin
      case ($urandom_range(3))
        0: aim = lo;
        1: aim = lo + 1;
        2: aim = hi - 1;
        default: aim = hi;
      endcase
      spread = 0;
    end else if (hi > lo + 1) begin
      aim = $urandom_range(hi - 1, lo + 1);
    end else begin
      aim = $urandom_range(SampleTop);
    end
    if (aim < 0) aim = 0;
    else if (aim > SampleTop) aim = SampleTop;
  endfunction

  function automatic logic [SampleW-1:0] next_sample();
    int v;
    if (frame_cnt == 0) pick_aim();
    if (wild || $urandom_range(11) == 0) begin
      case ($urandom_range(3))
        0: v = 0;
        1: v = SampleTop;
        default: v = $urandom_range(SampleTop);
      endcase
    end else begin
      v = aim - spread + int'($urandom_range(2 * spread));
      if (v < 0) v = 0;
      else if (v > SampleTop) v = SampleTop;
    end
    return v[SampleW-1:0];
  endfunction

  function automatic void random_window(output logic [SampleW-1:0] lo,
                                        output logic [SampleW-1:0] hi);
    int l;
    int h;
    l = $urandom_range(SampleTop - 1);
    if ($urandom_range(5) == 0) h = $urandom_range(l);
    else h = l + int'($urandom_range(700, 1));
    if (h > SampleTop) h = SampleTop;
    lo = l[SampleW-1:0];
    hi = h[SampleW-1:0];
  endfunction

  function automatic bounds_t random_bounds();
    bounds_t b;
    random_window(b.standby_low, b.standby_high);
    random_window(b.detected_low, b.detected_high);
    random_window(b.ready_low, b.ready_high);
    return b;
  endfunction

  task automatic apb_write(input logic [RegIdxW-1:0] idx, input logic [SampleW-1:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = ($urandom << SampleW) | ApbDataW'(value);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx <= RegReadyHigh) bound_q[idx] = value;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic apb_read(input logic [RegIdxW-1:0] idx);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = {idx, 2'b00};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[SampleW-1:0] != bound_q[idx]) begin
      $display("%0t: register %0d read mismatch, expected %0d, actual %0d",
               $time, idx, bound_q[idx], prdata[SampleW-1:0]);
      mismatches++;
    end
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic load_bounds(input bounds_t b);
    apb_write(RegStandbyLow, b.standby_low);
    apb_write(RegStandbyHigh, b.standby_high);
    apb_write(RegDetectedLow, b.detected_low);
    apb_write(RegDetectedHigh, b.detected_high);
    apb_write(RegReadyLow, b.ready_low);
    apb_write(RegReadyHigh, b.ready_high);
    for (int i = 0; i <= int'(RegReadyHigh); i++) apb_read(RegIdxW'(i));
  endtask

  task automatic drain_reports();
    s_axis_tvalid_i = 1'b0;
    while (report_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic settle();
    drain_reports();
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic send_sample(input logic [SampleW-1:0] s, input logic typed, input report_t given);
    logic    made;
    report_t rep;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      s_axis_tdata_i = InTdataW'($urandom_range(SampleTop));
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i = InTdataW'(s);
    do @(posedge clk_i); while (!s_axis_tready_o);
    take_sample(s, made, rep);
    if (typed) begin
      made = 1'b1;
      rep = given;
    end
    if (made) report_q.push_back(rep);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    m_axis_tready_i = ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    report_t            want;
    logic [StateW-1:0]  got_code;
    logic [SampleW-1:0] got_mean;
    got_code = m_axis_tdata_o[StateW-1:0];
    got_mean = m_axis_tdata_o[StateW +: SampleW];
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (report_q.size() == 0) begin
        $display("%0t: unexpected report, expected none, actual state %0d mean %0d",
                 $time, got_code, got_mean);
        mismatches++;
      end else begin
        want = report_q.pop_front();
        if (got_code != want.code) begin
          $display("%0t: state mismatch, expected %0d, actual %0d", $time, want.code, got_code);
          mismatches++;
        end
        if (got_mean != want.mean) begin
          $display("%0t: mean mismatch, expected %0d, actual %0d", $time, want.mean, got_mean);
          mismatches++;
        end
      end
    end
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("trimmed_mean_window_classifier regression: fail");
      $finish;
    end
  end

  initial begin
    phase_e ph;
    int     items;
    bound_q = '{StandbyLowRst, StandbyHighRst, DetectedLowRst, DetectedHighRst,
                ReadyLowRst, ReadyHighRst};
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int p = 0; p < int'(PhaseCount); p++) begin
      ph = phase_e'(p);
      case (p / 2)
        0: begin
          send_idle_pct = 13;
          recv_idle_pct = 59;
        end
        1: begin
          send_idle_pct = 59;
          recv_idle_pct = 13;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      settle();
      items = 250;
      case (ph)
        PhaseDefault: begin
          for (int i = 0; i <= int'(RegReadyHigh); i++) apb_read(RegIdxW'(i));
          for (int i = 0; i < DirectedLen; i++) begin
            send_sample(DirectedRows[i].sample, DirectedRows[i].typed, DirectedRows[i].want);
          end
        end
        PhaseOverlap: begin
          load_bounds('{standby_low: 12'd0, standby_high: 12'd1200,
                        detected_low: 12'd800, detected_high: 12'd2000,
                        ready_low: 12'd1500, ready_high: 12'd4095});
        end
        PhaseEmpty: begin
          load_bounds('{standby_low: 12'd4095, standby_high: 12'd0,
                        detected_low: 12'd2000, detected_high: 12'd2000,
                        ready_low: 12'd3000, ready_high: 12'd1000});
          items = 150;
        end
        PhaseRestore: begin
          load_bounds('{standby_low: StandbyLowRst, standby_high: StandbyHighRst,
                        detected_low: DetectedLowRst, detected_high: DetectedHighRst,
                        ready_low: ReadyLowRst, ready_high: ReadyHighRst});
          apb_write(RegSpareLow, SampleW'($urandom));
          apb_write(RegSpareHigh, SampleW'($urandom));
          for (int i = 0; i <= int'(RegReadyHigh); i++) apb_read(RegIdxW'(i));
          items = 275;
        end
        default: begin
          load_bounds(random_bounds());
          if (ph == PhaseRandomB) items = 300;
        end
      endcase
      repeat (items) begin
        if ($urandom_range(199) == 0) drain_reports();
        send_sample(next_sample(), 1'b0, '0);
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("trimmed_mean_window_classifier regression: pass");
    end else begin
      $display("trimmed_mean_window_classifier regression: fail");
    end
    $finish;
  end

endmodule
